// ===== rtl/arena_block_allocator_macros.svh =====
`ifndef ARENA_BLOCK_ALLOCATOR_MACROS_SVH
`define ARENA_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ABAL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abal assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ABAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abal assertion failed");

`endif

// ===== rtl/abal_pkg.sv =====
package abal_pkg;

  localparam int unsigned REQ_W     = 14;
  localparam int unsigned IN_OFF_W  = 13;
  localparam int unsigned OUT_OFF_W = 13;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } abal_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } abal_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESULT
  } abal_state_e;

  typedef struct packed {
    logic size_we;
    logic start_we;
  } abal_wr_t;

  typedef struct packed {
    logic                 valid;
    abal_status_e         status;
    logic [OUT_OFF_W-1:0] offset;
  } abal_res_t;

endpackage

// ===== rtl/abal_mem.sv =====
module abal_mem import abal_pkg::*; #(
  parameter int unsigned DEPTH   = 512,
  parameter int unsigned START_W = 13,
  localparam int unsigned IDX_W  = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  abal_wr_t           wr_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  logic [START_W-1:0] wr_start_i,
  input  logic [REQ_W-1:0]   wr_size_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output logic [START_W-1:0] rd_start_o,
  output logic [REQ_W-1:0]   rd_size_o
);

  logic [START_W-1:0] start_mem [DEPTH];
  logic [REQ_W-1:0]   size_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.start_we) begin
      start_mem[wr_addr_i] <= wr_start_i;
    end
    if (wr_i.size_we) begin
      size_mem[wr_addr_i] <= wr_size_i;
    end
    rd_start_o <= start_mem[rd_addr_i];
    rd_size_o  <= size_mem[rd_addr_i];
  end

endmodule

// ===== rtl/abal_walk.sv =====
module abal_walk import abal_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = 8192,
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned MAX_BLOCKS   = 512,
  localparam int unsigned START_W = $clog2(ARENA_BYTES),
  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [IN_OFF_W-1:0] payload_offset_i,
  output logic                in_stall_o,
  input  logic                out_ready_i,
  output abal_res_t           res_o,
  output logic [IDX_W-1:0]    rd_addr_o,
  input  logic [START_W-1:0]  rd_start_i,
  input  logic [REQ_W-1:0]    rd_size_i,
  output abal_wr_t            wr_o,
  output logic [IDX_W-1:0]    wr_addr_o,
  output logic [START_W-1:0]  wr_start_o,
  output logic [REQ_W-1:0]    wr_size_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = ((START_W > REQ_W) ? START_W : REQ_W) + 2;
  localparam logic [SUM_W-1:0] ARENA_S = SUM_W'(ARENA_BYTES);
  localparam logic [SUM_W-1:0] HDR_S   = SUM_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_BLOCKS);

  abal_state_e          state_q, state_d;
  abal_cmd_e            cmd_q;
  logic [REQ_W-1:0]     req_q;
  logic [IN_OFF_W-1:0]  off_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     idx_q;
  logic [START_W-1:0]   prev_start_q;
  logic [REQ_W-1:0]     prev_size_q;
  abal_status_e         status_q, status_d;
  logic [OUT_OFF_W-1:0] grant_q, grant_d;

  logic                 accept;
  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     last_idx;
  logic                 is_last;
  logic [SUM_W-1:0]     cur_s, cur_z, req_s, prev_s, pos, cur_pay;
  logic                 gap_hit, last_fit, app_fit, tbl_full, free_hit, first_fit;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign is_last  = (idx_q == last_idx);

  assign cur_s   = SUM_W'(rd_start_i);
  assign cur_z   = SUM_W'(rd_size_i);
  assign req_s   = SUM_W'(req_q);
  assign prev_s  = SUM_W'(prev_start_q);
  assign cur_pay = cur_s + HDR_S;
  assign pos     = cur_pay + cur_z;

  // free block in front of the current one whose gap is exactly the request
  assign gap_hit   = (idx_q != '0) && (prev_size_q == '0) &&
                     (prev_s + HDR_S + req_s == cur_s);
  assign last_fit  = (rd_size_i == '0) && (cur_pay + req_s <= ARENA_S);
  assign app_fit   = (pos + HDR_S + req_s <= ARENA_S);
  assign tbl_full  = (count_q >= MAX_C);
  assign free_hit  = (cur_pay == SUM_W'(off_q));
  assign first_fit = (HDR_S + SUM_W'(request_bytes_i) <= ARENA_S);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    status_d   = status_q;
    grant_d    = grant_q;
    rd_addr_o  = idx_q + IDX_W'(1);
    wr_o       = '0;
    wr_addr_o  = idx_q;
    wr_start_o = '0;
    wr_size_o  = req_q;
    res_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        rd_addr_o = '0;
        if (accept) begin
          if (abal_cmd_e'(command_i) == CMD_ALLOC) begin
            if (request_bytes_i == '0) begin
              status_d = STAT_NOFIT;
              grant_d  = '0;
              state_d  = S_RESULT;
            end else if (count_q == '0) begin
              if (first_fit) begin
                wr_o.size_we  = 1'b1;
                wr_o.start_we = 1'b1;
                wr_addr_o     = '0;
                wr_size_o     = request_bytes_i;
                count_d       = CNT_W'(1);
                status_d      = STAT_OK;
                grant_d       = OUT_OFF_W'(HEADER_BYTES);
              end else begin
                status_d = STAT_NOFIT;
                grant_d  = '0;
              end
              state_d = S_RESULT;
            end else begin
              state_d = S_WALK;
            end
          end else if (count_q == '0) begin
            status_d = STAT_NOTFOUND;
            grant_d  = '0;
            state_d  = S_RESULT;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (gap_hit) begin
            wr_o.size_we = 1'b1;
            wr_addr_o    = idx_q - IDX_W'(1);
            status_d     = STAT_OK;
            grant_d      = OUT_OFF_W'(prev_s + HDR_S);
            state_d      = S_RESULT;
          end else if (is_last) begin
            state_d = S_RESULT;
            grant_d = '0;
            if (last_fit) begin
              wr_o.size_we = 1'b1;
              status_d     = STAT_OK;
              grant_d      = OUT_OFF_W'(cur_pay);
            end else if (!app_fit) begin
              status_d = STAT_NOFIT;
            end else if (tbl_full) begin
              status_d = STAT_FULL;
            end else begin
              // append a new block right behind the last payload
              wr_o.size_we  = 1'b1;
              wr_o.start_we = 1'b1;
              wr_addr_o     = count_q[IDX_W-1:0];
              wr_start_o    = START_W'(pos);
              count_d       = count_q + CNT_W'(1);
              status_d      = STAT_OK;
              grant_d       = OUT_OFF_W'(pos + HDR_S);
            end
          end
        end else begin
          grant_d = '0;
          if (free_hit) begin
            wr_o.size_we = 1'b1;
            wr_size_o    = '0;
            status_d     = STAT_OK;
            state_d      = S_RESULT;
          end else if (is_last) begin
            status_d = STAT_NOTFOUND;
            state_d  = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        res_o.valid  = 1'b1;
        res_o.status = status_q;
        res_o.offset = grant_q;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    grant_q  <= grant_d;
    if (accept) begin
      cmd_q <= abal_cmd_e'(command_i);
      req_q <= request_bytes_i;
      off_q <= payload_offset_i;
      idx_q <= '0;
    end else if (state_q == S_WALK) begin
      idx_q        <= idx_q + IDX_W'(1);
      prev_start_q <= rd_start_i;
      prev_size_q  <= rd_size_i;
    end
  end

endmodule

// ===== rtl/arena_block_allocator.sv =====
// Arena block allocator: keeps an 8 KiB-style byte arena as an ordered chain of blocks, each a
// header of HEADER_BYTES followed by its payload, with start and size held in two on-chip
// tables of MAX_BLOCKS entries. An allocate item reuses the first free inner block whose gap
// fits the request exactly, else a free last block that fits, else appends a block; a free
// item marks the block with the matching payload offset free. One item is in work at a time:
// the walk reads the chain from its first entry until the answer is known (at most the
// current block count of entries), one table entry per cycle through the single read port;
// requests that need no walk (empty chain, zero size) go straight to the result. The result
// waits in the walk until the output register can take it, so a stalled output with a full
// output register holds the next item back.
module arena_block_allocator import abal_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = 8192,
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned MAX_BLOCKS   = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [REQ_W-1:0]     request_bytes_i,
  input  logic [IN_OFF_W-1:0]  payload_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [OUT_OFF_W-1:0] granted_offset_o
);

  localparam int unsigned START_W = $clog2(ARENA_BYTES);
  localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);

  abal_res_t            res;
  abal_wr_t             wr;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [START_W-1:0]   rd_start, wr_start;
  logic [REQ_W-1:0]     rd_size, wr_size;
  logic                 out_ready;
  logic                 out_valid_q;
  abal_status_e         status_q;
  logic [OUT_OFF_W-1:0] grant_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  abal_walk #(
    .ARENA_BYTES (ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_walk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .request_bytes_i (request_bytes_i),
    .payload_offset_i(payload_offset_i),
    .in_stall_o      (in_stall_o),
    .out_ready_i     (out_ready),
    .res_o           (res),
    .rd_addr_o       (rd_addr),
    .rd_start_i      (rd_start),
    .rd_size_i       (rd_size),
    .wr_o            (wr),
    .wr_addr_o       (wr_addr),
    .wr_start_o      (wr_start),
    .wr_size_o       (wr_size)
  );

  abal_mem #(
    .DEPTH  (MAX_BLOCKS),
    .START_W(START_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_start_i(wr_start),
    .wr_size_i (wr_size),
    .rd_addr_i (rd_addr),
    .rd_start_o(rd_start),
    .rd_size_o (rd_size)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && out_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_ready) begin
      status_q <= res.status;
      grant_q  <= res.offset;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = grant_q;

endmodule

// ===== rtl/abal_chk.sv =====
`include "arena_block_allocator_macros.svh"

module abal_chk import abal_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 command_i,
  input logic [REQ_W-1:0]     request_bytes_i,
  input logic [IN_OFF_W-1:0]  payload_offset_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [OUT_OFF_W-1:0] granted_offset_o
);

  logic any_req;

  // request fields are only looked at while an item is offered
  assign any_req = in_valid_i && (command_i || (request_bytes_i != '0) ||
                                  (payload_offset_i != '0) || 1'b1);

  `ABAL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(granted_offset_o))
  `ABAL_ASSERT_IMP(a_fail_zero, out_valid_o && (status_o != STAT_OK), granted_offset_o == '0)
  `ABAL_ASSERT_NEXT(a_one_item, any_req && !in_stall_o, in_stall_o)

endmodule

bind arena_block_allocator abal_chk u_abal_chk (.*);
